@@ rtl/meo_pkg.sv @@
// shared types, constants and helpers for the mecanum odometry unit
package meo_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned TickW   = 32;
  localparam int unsigned GainW   = 32;
  localparam int unsigned VelW    = 32;
  localparam int unsigned NumLane = 3;
  // |sum| <= 2^33, times up to four factors, one of them below 2^20: under 150 bits
  localparam int unsigned MagW    = 35;
  localparam int unsigned ProdW   = 160;
  localparam int unsigned QuoW    = 160;
  localparam int unsigned CntW    = 8;
  localparam int unsigned DivCntW = 8;
  localparam logic [31:0] UsPerS  = 32'd1000000;

  localparam logic [1:0] RegDecim  = 2'd0;
  localparam logic [1:0] RegTick   = 2'd1;
  localparam logic [1:0] RegRadius = 2'd2;
  localparam logic [1:0] RegSpin   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_DONE
  } lane_state_t;

  typedef struct packed {
    logic        start;
    logic [2:0]  nfac;
    logic [5:0]  shift;
  } lane_cmd_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

endpackage

@@ rtl/meo_lane.sv @@
// one lane: signed sum times a chain of gains, divided by the interval, saturated
module meo_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  meo_pkg::lane_cmd_t            cmd,
  input  logic signed [meo_pkg::MagW-1:0] sum,
  input  logic [meo_pkg::GainW-1:0]     fac0,
  input  logic [meo_pkg::GainW-1:0]     fac1,
  input  logic [meo_pkg::GainW-1:0]     fac2,
  input  logic [meo_pkg::GainW-1:0]     fac3,
  input  logic [meo_pkg::TimeW-1:0]     dt,
  output meo_pkg::lane_stat_t           stat,
  output logic [meo_pkg::VelW-1:0]      result
);
  import meo_pkg::*;

  lane_state_t st_r, st_nxt;
  logic [ProdW-1:0]   acc_r, acc_nxt;
  logic [ProdW-1:0]   quo_r, quo_nxt;
  logic [TimeW:0]     rem_r, rem_nxt;
  logic [2:0]         fidx_r, fidx_nxt;
  logic [DivCntW-1:0] bit_r, bit_nxt;
  logic               neg_r, neg_nxt;
  logic [2:0]         nfac_r, nfac_nxt;
  logic [5:0]         shift_r, shift_nxt;
  logic [VelW-1:0]    res_r, res_nxt;

  logic [GainW-1:0]   fsel;
  logic [ProdW-1:0]   shifted;
  logic [TimeW:0]     rtry;
  logic [MagW-1:0]    mag;
  logic [ProdW-1:0]   qs;
  logic               huge;

  assign mag = sum[MagW-1] ? MagW'(-sum) : MagW'(sum);

  always_comb begin
    case (fidx_r)
      3'd0:    fsel = fac0;
      3'd1:    fsel = fac1;
      3'd2:    fsel = fac2;
      default: fsel = fac3;
    endcase
  end

  // one 32x32 limb product per cycle, five limbs per factor; the accumulator
  // rotates so the limb being worked on is always in the low 32 bits
  logic [2:0]  limb_r, limb_nxt;
  logic [31:0] carry_r, carry_nxt;
  logic [63:0] lprod;

  always_comb begin
    lprod = 64'(acc_r[31:0]) * 64'(fsel) + 64'(carry_r);
  end

  assign rtry = {rem_r[TimeW-1:0], acc_r[ProdW-1]};

  always_comb begin
    qs = (shift_r[5]) ? (quo_r >> 32) : (quo_r >> 16);
    huge = |qs[ProdW-1:VelW];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (cmd.start) st_nxt = ST_MUL;
      ST_MUL:  if (limb_r == 3'd4 && fidx_r == nfac_r - 3'd1) st_nxt = ST_DIV;
      ST_DIV:  if (bit_r == DivCntW'(QuoW - 1)) st_nxt = ST_DONE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r; quo_nxt = quo_r; rem_nxt = rem_r; fidx_nxt = fidx_r;
    bit_nxt = bit_r; neg_nxt = neg_r; nfac_nxt = nfac_r; shift_nxt = shift_r;
    res_nxt = res_r; limb_nxt = limb_r; carry_nxt = carry_r;
    unique case (st_r)
      ST_IDLE: begin
        acc_nxt = ProdW'(mag);
        neg_nxt = sum[MagW-1];
        nfac_nxt = cmd.nfac;
        shift_nxt = cmd.shift;
        fidx_nxt = '0; limb_nxt = '0; carry_nxt = '0; bit_nxt = '0;
        rem_nxt = '0; quo_nxt = '0;
      end
      ST_MUL: begin
        // limbs rotate through acc: the low limb's product enters at the top, acc shifts right by 32
        acc_nxt = {lprod[31:0], acc_r[ProdW-1:32]};
        carry_nxt = lprod[63:32];
        if (limb_r == 3'd4) begin
          limb_nxt = '0; carry_nxt = '0; fidx_nxt = fidx_r + 3'd1;
        end else begin
          limb_nxt = limb_r + 3'd1;
        end
      end
      ST_DIV: begin
        acc_nxt = {acc_r[ProdW-2:0], 1'b0};
        if (rtry >= {1'b0, dt}) begin
          rem_nxt = rtry - {1'b0, dt};
          quo_nxt = {quo_r[QuoW-2:0], 1'b1};
        end else begin
          rem_nxt = rtry;
          quo_nxt = {quo_r[QuoW-2:0], 1'b0};
        end
        bit_nxt = bit_r + DivCntW'(1);
      end
      ST_DONE: begin
        if (neg_r) begin
          if (huge || qs[VelW-1:0] > 32'h8000_0000) res_nxt = 32'h8000_0000;
          else res_nxt = 32'(0) - qs[VelW-1:0];
        end else begin
          if (huge || qs[VelW-1]) res_nxt = 32'h7FFF_FFFF;
          else res_nxt = qs[VelW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
    acc_r <= acc_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt; fidx_r <= fidx_nxt;
    bit_r <= bit_nxt; neg_r <= neg_nxt; nfac_r <= nfac_nxt; shift_r <= shift_nxt;
    res_r <= res_nxt; limb_r <= limb_nxt; carry_r <= carry_nxt;
  end

  assign stat.done = (st_r == ST_DONE);
  assign result = res_nxt;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && cmd.start) |=> st_r == ST_MUL) else $error("lane start lost");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DONE |=> st_r == ST_IDLE) else $error("lane done stuck");
  a_limb_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MUL |-> limb_r <= 3'd4) else $error("limb out of range");
`endif
endmodule

@@ rtl/mecanum_encoder_odometry_unit.sv @@
// top level: sample intake, three kinematic lanes and result merge
// channel | dir | tdata fields (low bit first)                          | tuser
// in      | in  | time_us, ticks_fl, ticks_fr, ticks_rl, ticks_rr (176) | -
// out     | out | vel_x, vel_y, yaw_rate, interval_us (128)            | bad_interval
// cfg     | in  | decimation, tick_gain, radius_quarter, spin_gain     | -
// a result-producing item with a nonzero interval passes, after its accept, through
// the start flag, lane load, 20 limb multiplies in the yaw lane, a 160 step
// restoring divide, saturate and merge before out_tvalid; lanes run in parallel
// a zero-interval result is valid in the cycle after its accept; other items
// do not hold off the input
// rst_n is synchronous active low and restores register defaults and state
// the result register holds while out_tready is low; input is held off
// until the lanes are free and the result register is empty again
module mecanum_encoder_odometry_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [175:0] in_tdata,   // time_us, ticks fl, fr, rl, rr
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // vel_x, vel_y, yaw_rate, interval_us
  output logic         out_tuser,  // bad_interval
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import meo_pkg::*;

  logic [7:0]  decim_r;
  logic [31:0] tick_r, radius_r, spin_r;
  logic        have_r;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [TimeW-1:0] ptime_r, dt_r;
  logic [TickW-1:0] pt_r [4];
  logic signed [MagW-1:0] sx_r, sy_r, sw_r;
  logic        busy_r, busy_nxt;
  logic        ov_r;
  logic [127:0] od_r;
  logic        ou_r;
  logic        go_r;

  logic acc;
  logic [TimeW-1:0] t_in, dtn;
  logic signed [TickW-1:0] d [4];
  logic fire;
  logic [7:0] decim_eff;
  lane_cmd_t cxy, cw;
  lane_stat_t s0, s1, s2;
  logic [VelW-1:0] r0, r1, r2;

  assign in_tready = !busy_r && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign t_in = in_tdata[47:0];
  assign dtn = t_in - ptime_r;
  assign decim_eff = (decim_r == 8'd0) ? 8'd1 : decim_r;
  assign cnt_nxt = cnt_r + 8'd1;
  assign fire = acc && have_r && (cnt_nxt >= decim_eff);

  always_comb begin
    for (int i = 0; i < 4; i++)
      d[i] = in_tdata[48+32*i +: 32] - pt_r[i];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r <= 8'd4; tick_r <= 32'd65536; radius_r <= 32'd16384; spin_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegDecim:  decim_r  <= cfg_data[7:0];
        RegTick:   tick_r   <= cfg_data;
        RegRadius: radius_r <= cfg_data;
        RegSpin:   spin_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cxy.start = go_r; assign cxy.nfac = 3'd3; assign cxy.shift = 6'd16;
  assign cw.start  = go_r; assign cw.nfac  = 3'd4; assign cw.shift  = 6'd32;

  meo_lane u_x (.clk, .rst_n, .cmd(cxy), .sum(sx_r), .fac0(tick_r), .fac1(radius_r),
    .fac2(UsPerS), .fac3(spin_r), .dt(dt_r), .stat(s0), .result(r0));
  meo_lane u_y (.clk, .rst_n, .cmd(cxy), .sum(sy_r), .fac0(tick_r), .fac1(radius_r),
    .fac2(UsPerS), .fac3(spin_r), .dt(dt_r), .stat(s1), .result(r1));
  meo_lane u_w (.clk, .rst_n, .cmd(cw), .sum(sw_r), .fac0(tick_r), .fac1(radius_r),
    .fac2(UsPerS), .fac3(spin_r), .dt(dt_r), .stat(s2), .result(r2));

  // lane w finishes last (one more factor); merge when it is done
  assign busy_nxt = busy_r ? !s2.done : (fire && dtn != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0; cnt_r <= '0; ptime_r <= '0; busy_r <= 1'b0; ov_r <= 1'b0;
      go_r <= 1'b0;
      for (int i = 0; i < 4; i++) pt_r[i] <= '0;
    end else begin
      go_r <= 1'b0;
      busy_r <= busy_nxt;
      if (acc) begin
        // reference moves only on the first item and on result items
        if (!have_r || fire) begin
          ptime_r <= t_in;
          for (int i = 0; i < 4; i++) pt_r[i] <= in_tdata[48+32*i +: 32];
        end
        if (!have_r) have_r <= 1'b1;
        else cnt_r <= fire ? 8'd0 : cnt_nxt;
      end
      if (fire) begin
        dt_r <= dtn;
        sx_r <= MagW'(d[0]) + MagW'(d[1]) + MagW'(d[2]) + MagW'(d[3]);
        sy_r <= -MagW'(d[0]) + MagW'(d[1]) + MagW'(d[2]) - MagW'(d[3]);
        sw_r <= -MagW'(d[0]) + MagW'(d[1]) - MagW'(d[2]) + MagW'(d[3]);
        if (dtn == '0) begin
          ov_r <= 1'b1; od_r <= '0; ou_r <= 1'b1;
        end else go_r <= 1'b1;
      end else if (busy_r && s2.done) begin
        ov_r <= 1'b1; ou_r <= 1'b0;
        od_r <= {(|dt_r[47:32]) ? 32'hFFFF_FFFF : dt_r[31:0], r2, r1, r0};
      end else if (ov_r && out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready) else $error("accept while busy");
  a_lanes_align: assert property (@(posedge clk) disable iff (!rst_n)
    s0.done == s1.done) else $error("xy lanes out of step");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && s2.done) |-> !ov_r) else $error("result overwritten");
`endif
endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the mecanum odometry unit
`timescale 1ns / 100ps

module tb_top;
  import meo_pkg::*;

  typedef struct packed {
    logic [31:0] ticks_rr;
    logic [31:0] ticks_rl;
    logic [31:0] ticks_fr;
    logic [31:0] ticks_fl;
    logic [47:0] time_us;
  } sample_t;

  typedef struct packed {
    logic        bad_interval;
    logic [31:0] interval_us;
    logic [31:0] yaw_rate;
    logic [31:0] vel_y;
    logic [31:0] vel_x;
  } odom_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;   // time_us, ticks fl, fr, rl, rr
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // vel_x, vel_y, yaw_rate, interval_us
  logic         out_tuser;       // bad_interval
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = RegDecim;
  logic [31:0]  cfg_data = '0;

  mecanum_encoder_odometry_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state and register copies
  logic [7:0]  m_decim;
  logic [31:0] m_tick, m_radius, m_spin;
  logic        m_have_first;
  logic [7:0]  m_count;
  logic [47:0] m_prev_time;
  logic [31:0] m_prev_ticks [4];

  sample_t sample_queue [$];
  odom_t   odom_expected [$];
  int      mismatches = 0;
  int      cycles = 0;
  int      hold_cycles = 0;
  bit      hold_start = 1'b0;
  bit      hold_used = 1'b0;

  // sign-magnitude sum times factors over dt, truncated then saturated
  function automatic logic [31:0] scale_velocity(longint s, logic [31:0] f0, logic [31:0] f1,
                                                 logic [31:0] f2, logic [31:0] f3, bit use_f3,
                                                 logic [47:0] dt, int shift);
    logic [191:0] num, quo;
    bit neg;
    neg = s < 0;
    num = neg ? 192'(-s) : 192'(s);
    num = num * f0 * f1 * f2;
    if (use_f3) num = num * f3;
    quo = (num / dt) >> shift;
    if (neg) begin
      if (quo > 192'h8000_0000) return 32'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 192'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  function automatic void odom_reset();
    m_decim = 8'd4; m_tick = 32'd65536; m_radius = 32'd16384; m_spin = 32'd65536;
    m_have_first = 1'b0; m_count = '0; m_prev_time = '0;
    foreach (m_prev_ticks[i]) m_prev_ticks[i] = '0;
  endfunction

  function automatic void odom_accept(sample_t s);
    logic [31:0] cur [4];
    longint d [4];
    longint sx, sy, sw;
    logic [47:0] dt;
    odom_t r;
    cur[0] = s.ticks_fl; cur[1] = s.ticks_fr; cur[2] = s.ticks_rl; cur[3] = s.ticks_rr;
    if (!m_have_first) begin
      m_have_first = 1'b1;
      m_prev_time = s.time_us;
      foreach (cur[i]) m_prev_ticks[i] = cur[i];
      return;
    end
    m_count = m_count + 8'd1;
    if (m_count < m_decim) return;
    m_count = '0;
    dt = s.time_us - m_prev_time;
    foreach (cur[i]) begin
      d[i] = longint'($signed(cur[i] - m_prev_ticks[i]));
      m_prev_ticks[i] = cur[i];
    end
    m_prev_time = s.time_us;
    r = '0;
    if (dt == 0) begin
      r.bad_interval = 1'b1;
    end else begin
      sx = d[0] + d[1] + d[2] + d[3];
      sy = -d[0] + d[1] + d[2] - d[3];
      sw = -d[0] + d[1] - d[2] + d[3];
      r.vel_x = scale_velocity(sx, m_tick, m_radius, UsPerS, 0, 0, dt, 16);
      r.vel_y = scale_velocity(sy, m_tick, m_radius, UsPerS, 0, 0, dt, 16);
      r.yaw_rate = scale_velocity(sw, m_tick, m_radius, UsPerS, m_spin, 1, dt, 32);
      r.interval_us = (dt > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
    end
    odom_expected.push_back(r);
  endfunction

  function automatic int short_or_long_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // driver: one item from the pending queue, with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) odom_accept(sample_t'(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          in_tdata <= sample_queue.pop_front();
          in_tvalid <= 1'b1;
          in_gap <= short_or_long_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down in its own process
  always @(posedge clk) begin
    if (hold_start && !hold_used) begin
      hold_used <= 1'b1;
      hold_cycles <= 3000;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor: compares each result item with the oldest expectation
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        odom_t got, exp_r;
        got = {out_tuser, out_tdata};
        if (odom_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result item %h", got);
        end else begin
          exp_r = odom_expected.pop_front();
          if (got !== exp_r) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch vx %h/%h vy %h/%h w %h/%h dt %h/%h bad %b/%b",
                       exp_r.vel_x, got.vel_x, exp_r.vel_y, got.vel_y,
                       exp_r.yaw_rate, got.yaw_rate, exp_r.interval_us,
                       got.interval_us, exp_r.bad_interval, got.bad_interval);
          end
        end
      end
      // long hold-off lets the block fill up and stall its input
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) out_gap <= short_or_long_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegDecim:  m_decim = val[7:0];
      RegTick:   m_tick = val;
      RegRadius: m_radius = val;
      RegSpin:   m_spin = val;
      default: ;
    endcase
  endtask

  // idle point: queue drained, no result pending, and the block's long pass over
  task automatic wait_idle();
    while (sample_queue.size() > 0 || in_tvalid || odom_expected.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_tick();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $urandom_range(2000) - 1000;
    endcase
  endfunction

  sample_t cur_s;
  logic [47:0] t_now;

  // plausible motion run: mostly growing time, modest tick steps, jumps and wraps now and then
  task automatic queue_motion(int n);
    repeat (n) begin
      case ($urandom_range(9))
        0: t_now = t_now;
        1: t_now = 48'({$urandom(), $urandom()});
        2: t_now = t_now + {$urandom(), 16'h0};
        default: t_now = t_now + $urandom_range(50000, 1);
      endcase
      cur_s.time_us = t_now;
      if ($urandom_range(9) == 0) begin
        cur_s.ticks_fl = $urandom(); cur_s.ticks_fr = $urandom();
        cur_s.ticks_rl = $urandom(); cur_s.ticks_rr = $urandom();
      end else begin
        cur_s.ticks_fl += $urandom_range(4000) - 2000;
        cur_s.ticks_fr += $urandom_range(4000) - 2000;
        cur_s.ticks_rl += $urandom_range(4000) - 2000;
        cur_s.ticks_rr += $urandom_range(4000) - 2000;
      end
      sample_queue.push_back(cur_s);
    end
  endtask

  initial begin
    odom_reset();
    t_now = '0;
    cur_s = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: default registers, extremes, zero interval, wraps
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0});
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0});
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0});
    sample_queue.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 48'h0});
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0});   // zero interval
    sample_queue.push_back('{32'h1, 32'h1, 32'h1, 32'h1, 48'h1});
    sample_queue.push_back('{32'hFFFFFFFF, 32'h1, 32'h1, 32'hFFFFFFFF, 48'h2});
    sample_queue.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                             48'hFFFFFFFFFFFF});  // time wrap
    sample_queue.push_back('{32'h5, 32'h9, 32'hFFFFFFF0, 32'h3, 48'h10});
    wait_idle();
    write_reg(RegDecim, 32'd1);
    write_reg(RegTick, 32'hFFFF_FFFF);
    write_reg(RegRadius, 32'hFFFF_FFFF);
    write_reg(RegSpin, 32'hFFFF_FFFF);
    sample_queue.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                             48'h11});
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0000_1_0000_0011});
    sample_queue.push_back('{32'h3, 32'h0, 32'h0, 32'h0, 48'h7FFF_FFFF_FFFF});
    wait_idle();
    write_reg(RegDecim, 32'd0);   // acts as one
    write_reg(RegTick, 32'd0);
    write_reg(RegRadius, 32'd0);
    write_reg(RegSpin, 32'd0);
    sample_queue.push_back('{32'h1234, 32'h1, 32'h2, 32'h3, 48'h123});
    sample_queue.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 48'h0});
    wait_idle();

    // random phases across several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(RegDecim, 32'd255);
        1: write_reg(RegDecim, 32'd2);
        default: write_reg(RegDecim, $urandom_range(ph == 7 ? 1 : 6, 1));
      endcase
      write_reg(RegTick, (ph % 3 == 0) ? $urandom() : $urandom_range(200000));
      write_reg(RegRadius, (ph % 4 == 1) ? $urandom() : $urandom_range(40000));
      write_reg(RegSpin, (ph % 2 == 0) ? $urandom() : $urandom_range(300000));
      queue_motion(ph == 0 ? 60 : 110);
      if (ph == 3) begin
        hold_start = 1'b1;   // receiver stalls while items keep coming
      end
      if (ph == 0) begin
        // lowering decimation below the counter mid-run
        wait_idle();
        write_reg(RegDecim, 32'd3);
        queue_motion(5);
      end
      wait_idle();
    end

    if (mismatches == 0 && odom_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ mecanum_encoder_odometry_unit.f @@
rtl/meo_pkg.sv
rtl/meo_lane.sv
rtl/mecanum_encoder_odometry_unit.sv
tb/tb_top.sv
